// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define FRS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define FRS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/frs_pkg.sv -----
// Types and constants of the feeder reload and fire sequencer.
package frs_pkg;

  localparam int unsigned InWidth     = 69;
  localparam int unsigned InDataWidth = 72;
  localparam int unsigned OutWidth     = 38;
  localparam int unsigned OutDataWidth = 40;
  localparam int unsigned CfgIdxWidth  = 8;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgMaxFeedTicks  = 8'd0,
    CfgMaxStallCount = 8'd1,
    CfgReverseOffset = 8'd2,
    CfgFeedSpeed     = 8'd3,
    CfgReverseSpeed  = 8'd4,
    CfgFireOffset    = 8'd5,
    CfgFireSpeed     = 8'd6
  } cfg_idx_e;

  localparam logic [15:0] MaxFeedTicksRst  = 16'd1000;
  localparam logic [7:0]  MaxStallCountRst = 8'd3;

  typedef struct packed {
    logic [15:0]        max_feed_ticks;
    logic [7:0]         max_stall_count;
    logic signed [31:0] reverse_offset;
    logic signed [15:0] feed_speed;
    logic signed [15:0] reverse_speed;
    logic signed [31:0] fire_offset;
    logic signed [15:0] fire_speed;
  } cfg_t;

  // Input request, packed lowest field in the lowest bits.
  typedef struct packed {
    logic signed [31:0] limiter_position;
    logic signed [31:0] feeder_position;
    logic               feeder_stalled;
    logic               arm_pulse;
    logic               link_online;
    logic               burst_cmd;
    logic               single_cmd;
  } in_t;

  // Result request, packed lowest field in the lowest bits.
  typedef struct packed {
    logic               reload_done;
    logic               shot_done;
    logic               shot_busy;
    logic               init_done;
    logic               is_loaded;
    logic               drive_enable;
    logic signed [15:0] limiter_speed_target;
    logic signed [15:0] feeder_speed_target;
  } res_t;

endpackage

// ----- hdl/feeder_reload_and_fire_sequencer_core.sv -----
// Feeder reload and fire sequencer: top level with state, input and result registers.
//
// Channel  Direction  Handshake                    Payload
// s_axis   in         s_axis_tvalid_i/tready_o     control tick inputs, 72-bit tdata
// m_axis   out        m_axis_tvalid_o/tready_i     speed targets and status, 40-bit tdata
// cfg      in         cfg_valid_i/cfg_ready_o      register index and write data
//
// One request per clock cycle is accepted while results are taken, and one result is produced per request.
// Each request passes the input register and then the state update
// stage, which writes all sequencer state and the result register together.
// Reset (rst_ni low, asynchronous) clears sequencer state and valid flags and loads register defaults.
// A held result stalls the state update stage; the input register still takes
// one request, so upstream only sees ready low when both stages are full.
`include "assert_macros.svh"

module feeder_reload_and_fire_sequencer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // [0] single_cmd, [1] burst_cmd, [2] link_online, [3] arm_pulse,
  // [4] feeder_stalled, [36:5] feeder_position, [68:37] limiter_position, zero pad
  input  logic [frs_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [15:0] feeder_speed_target, [31:16] limiter_speed_target, [32] drive_enable,
  // [33] is_loaded, [34] init_done, [35] shot_busy, [36] shot_done,
  // [37] reload_done, zero pad
  output logic [frs_pkg::OutDataWidth-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [frs_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [frs_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  typedef enum logic [1:0] {
    PhSleep   = 2'd0,
    PhFeed    = 2'd1,
    PhReverse = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ShotIdle     = 2'd0,
    ShotRunning  = 2'd1,
    ShotFinished = 2'd2
  } shot_e;

  // Configuration registers. Writes are taken at any time; the user only
  // writes while the block is idle.
  frs_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_feed_ticks:  frs_pkg::MaxFeedTicksRst,
                 max_stall_count: frs_pkg::MaxStallCountRst,
                 default:         '0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        frs_pkg::CfgMaxFeedTicks:  cfg_q.max_feed_ticks  <= cfg_data_i[15:0];
        frs_pkg::CfgMaxStallCount: cfg_q.max_stall_count <= cfg_data_i[7:0];
        frs_pkg::CfgReverseOffset: cfg_q.reverse_offset  <= cfg_data_i;
        frs_pkg::CfgFeedSpeed:     cfg_q.feed_speed      <= cfg_data_i[15:0];
        frs_pkg::CfgReverseSpeed:  cfg_q.reverse_speed   <= cfg_data_i[15:0];
        frs_pkg::CfgFireOffset:    cfg_q.fire_offset     <= cfg_data_i;
        frs_pkg::CfgFireSpeed:     cfg_q.fire_speed      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Handshake. The state stage advances when it holds a request and the
  // result register is free or being emptied this cycle.
  logic          in_valid_q;
  frs_pkg::in_t  in_q;
  logic          out_valid_q;
  frs_pkg::res_t res_q;
  frs_pkg::res_t res_d;
  logic          advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= s_axis_tdata_i[frs_pkg::InWidth-1:0];
    end
  end

  // Sequencer state.
  phase_e             phase_q, phase_d;
  logic [15:0]        ftc_q, ftc_d;
  logic [7:0]         stall_cnt_q, stall_cnt_d;
  logic signed [31:0] rev_target_q, rev_target_d;
  logic signed [15:0] feed_spd_q, feed_spd_d;
  logic               fire_phase_q, fire_phase_d;
  logic signed [31:0] fire_target_q, fire_target_d;
  logic signed [15:0] lim_spd_q, lim_spd_d;
  logic               loaded_q, loaded_d;
  logic               init_q, init_d;
  shot_e              shot_q, shot_d;
  logic               armed_q, armed_d;
  logic               burst_q, burst_d;

  // One reload step computed from the current state. Whether it is applied
  // is decided below, so at most one step happens per request.
  phase_e             rl_phase;
  logic [15:0]        rl_ftc;
  logic [7:0]         rl_stall_cnt;
  logic signed [31:0] rl_rev_target;
  logic signed [15:0] rl_feed_spd;
  logic               rl_done;
  logic [8:0]         stall_inc;

  always_comb begin
    rl_phase      = phase_q;
    rl_ftc        = ftc_q;
    rl_stall_cnt  = stall_cnt_q;
    rl_rev_target = rev_target_q;
    rl_feed_spd   = feed_spd_q;
    rl_done       = 1'b0;
    stall_inc     = {1'b0, stall_cnt_q} + 9'd1;
    unique case (phase_q)
      PhSleep: begin
        rl_phase = PhFeed;
      end
      PhFeed: begin
        if (!in_q.feeder_stalled) begin
          if (ftc_q >= cfg_q.max_feed_ticks) begin
            rl_done = 1'b1;
          end else begin
            rl_feed_spd = cfg_q.feed_speed;
            rl_ftc      = ftc_q + 16'd1;
          end
        end else begin
          rl_stall_cnt = stall_inc[7:0];
          if (stall_inc < {1'b0, cfg_q.max_stall_count}) begin
            rl_rev_target = in_q.feeder_position + cfg_q.reverse_offset;
            rl_phase      = PhReverse;
          end else begin
            rl_done = 1'b1;
          end
        end
      end
      PhReverse: begin
        if (in_q.feeder_stalled || (in_q.feeder_position <= rev_target_q)) begin
          rl_phase = PhFeed;
        end else begin
          rl_feed_spd = cfg_q.reverse_speed;
        end
      end
      default: ;
    endcase
    if (rl_done) begin
      rl_ftc       = '0;
      rl_feed_spd  = '0;
      rl_stall_cnt = '0;
      rl_phase     = PhSleep;
    end
  end

  // Per-request update in program order: arm latch, fire sequencer,
  // continuous fire, then online, init and reload handling.
  logic step_en;
  logic reload_done;
  logic shot_done;

  always_comb begin
    armed_d       = armed_q | in_q.arm_pulse;
    shot_d        = shot_q;
    fire_phase_d  = fire_phase_q;
    fire_target_d = fire_target_q;
    lim_spd_d     = lim_spd_q;
    loaded_d      = loaded_q;
    init_d        = init_q;
    burst_d       = burst_q;
    shot_done     = 1'b0;
    reload_done   = 1'b0;
    step_en       = 1'b0;

    if ((in_q.single_cmd && loaded_q && armed_d) || (shot_q == ShotRunning)) begin
      shot_d = ShotRunning;
      if (!fire_phase_q) begin
        fire_target_d = in_q.limiter_position + cfg_q.fire_offset;
        fire_phase_d  = 1'b1;
      end else if (in_q.limiter_position <= fire_target_q) begin
        lim_spd_d    = '0;
        fire_phase_d = 1'b0;
        loaded_d     = 1'b0;
        shot_d       = ShotFinished;
        armed_d      = 1'b0;
        shot_done    = 1'b1;
      end else begin
        lim_spd_d = cfg_q.fire_speed;
      end
    end

    // Continuous fire keeps reloading and uses up the request's reload step.
    if (in_q.burst_cmd) begin
      lim_spd_d   = cfg_q.fire_speed;
      step_en     = 1'b1;
      reload_done = rl_done;
      burst_d     = 1'b1;
    end else if (burst_q) begin
      lim_spd_d = '0;
      burst_d   = 1'b0;
      loaded_d  = 1'b0;
    end

    if (!in_q.link_online) begin
      init_d = 1'b0;
    end else if (!init_q) begin
      if (!in_q.burst_cmd) begin
        step_en = 1'b1;
        if (rl_done) begin
          reload_done = 1'b1;
          init_d      = 1'b1;
          loaded_d    = 1'b1;
        end
      end
    end else if (!loaded_d) begin
      if (!in_q.burst_cmd) begin
        step_en = 1'b1;
        if (rl_done) begin
          reload_done = 1'b1;
          loaded_d    = 1'b1;
        end
      end
    end

    phase_d      = step_en ? rl_phase      : phase_q;
    ftc_d        = step_en ? rl_ftc        : ftc_q;
    stall_cnt_d  = step_en ? rl_stall_cnt  : stall_cnt_q;
    rev_target_d = step_en ? rl_rev_target : rev_target_q;
    feed_spd_d   = step_en ? rl_feed_spd   : feed_spd_q;

    // Speed targets are forced to zero while the link is down.
    res_d.feeder_speed_target  = in_q.link_online ? feed_spd_d : '0;
    res_d.limiter_speed_target = in_q.link_online ? lim_spd_d : '0;
    res_d.drive_enable         = in_q.link_online;
    res_d.is_loaded            = loaded_d;
    res_d.init_done            = init_d;
    res_d.shot_busy            = (shot_d == ShotRunning);
    res_d.shot_done            = shot_done;
    res_d.reload_done          = reload_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhSleep;
      ftc_q         <= '0;
      stall_cnt_q   <= '0;
      rev_target_q  <= '0;
      feed_spd_q    <= '0;
      fire_phase_q  <= 1'b0;
      fire_target_q <= '0;
      lim_spd_q     <= '0;
      loaded_q      <= 1'b0;
      init_q        <= 1'b0;
      shot_q        <= ShotIdle;
      armed_q       <= 1'b0;
      burst_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else if (advance) begin
      phase_q       <= phase_d;
      ftc_q         <= ftc_d;
      stall_cnt_q   <= stall_cnt_d;
      rev_target_q  <= rev_target_d;
      feed_spd_q    <= feed_spd_d;
      fire_phase_q  <= fire_phase_d;
      fire_target_q <= fire_target_d;
      lim_spd_q     <= lim_spd_d;
      loaded_q      <= loaded_d;
      init_q        <= init_d;
      shot_q        <= shot_d;
      armed_q       <= armed_d;
      burst_q       <= burst_d;
      out_valid_q   <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(frs_pkg::OutDataWidth - frs_pkg::OutWidth){1'b0}}, res_q};

  // The limiter move runs exactly while a single shot is running. The state
  // is only defined once reset has been seen, so reset cycles pass.
  `FRS_ASSERT_ALWAYS(a_fire_phase_matches_shot,
                     !rst_ni || (fire_phase_q == (shot_q == ShotRunning)),
                     "fire phase out of step with shot state")
  // A completed reload always leaves the sequencer asleep.
  `FRS_ASSERT(a_reload_done_sleeps,
              (advance && res_d.reload_done) |=> (phase_q == PhSleep),
              "reload done but sequencer not asleep")
  // Stall count stays below its wrap point, so the 8-bit counter is enough.
  `FRS_ASSERT_ALWAYS(a_stall_cnt_range, !rst_ni || (stall_cnt_q != 8'hFF),
                     "stall count reached wrap point")
  // With drive disabled both speed targets leave as zero.
  `FRS_ASSERT(a_drive_off_zero,
              (out_valid_q && !res_q.drive_enable) |->
                ((res_q.feeder_speed_target == '0) && (res_q.limiter_speed_target == '0)),
              "speed target nonzero with drive off")

endmodule
